@@ hdl/ibs0_gap_histogram_defines.svh @@
// ----------------------------------------------------------------------------
// IBS0 gap histogram assertion macros
// Shared property forms for the checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef IBS0_GAP_HISTOGRAM_DEFINES_SVH
`define IBS0_GAP_HISTOGRAM_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define IBS0GH_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define IBS0GH_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hdl/ibs0gh_pkg.sv @@
// ----------------------------------------------------------------------------
// IBS0 gap histogram package
// Field widths, register indexes and the controller state type.
// ----------------------------------------------------------------------------
package ibs0gh_pkg;

   // Field and register widths.
   localparam int POS_W     = 31;
   localparam int COUNT_W   = 64;
   localparam int REG_W     = 10;
   localparam int DIVISOR_W = 20;

   // Base pairs in one kilobase.
   localparam int BP_PER_KB = 1000;

   // Configuration register indexes.
   localparam logic CSR_BIN_WIDTH_KB = 1'b0;
   localparam logic CSR_LAST_BIN     = 1'b1;

   // Result kinds.
   localparam logic KIND_BOUNDS = 1'b0;
   localparam logic KIND_BIN    = 1'b1;

   // Input actions.
   localparam logic ACT_SITE = 1'b0;
   localparam logic ACT_READ = 1'b1;

   // Controller states.
   typedef enum logic [5:0] {
      ST_CLEAR  = 6'b000001,
      ST_IDLE   = 6'b000010,
      ST_DIV    = 6'b000100,
      ST_RD_BIN = 6'b001000,
      ST_INC    = 6'b010000,
      ST_FIN    = 6'b100000
   } state_type;

endpackage

@@ hdl/ibs0_gap_histogram.sv @@
// A site that adds a gap goes through the bit-serial divider (31 quotient bits)
// and the bin update before the next input transfer is taken.
// Reset: synchronous; afterwards the histogram RAM is cleared one bin per
// cycle while input transfers are stalled.
// ----------------------------------------------------------------------------
// IBS0 gap histogram
// Tracks IBS0 sites of a sample pair, bins the gaps between them in a RAM
// and reports pair bounds and bin counts.
// ----------------------------------------------------------------------------
`include "ibs0_gap_histogram_defines.svh"

module ibs0_gap_histogram #(
   parameter int MAX_BINS = 1024
) (
   input  logic                           clock,
   input  logic                           reset,
   // Configuration writes.
   input  logic                           csr_we,
   input  logic                           csr_index,
   input  logic [ibs0gh_pkg::REG_W-1:0]   csr_wdata,
   // Input channel.
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic                           req_action,
   input  logic                           req_first_ref_hom,
   input  logic                           req_first_alt_hom,
   input  logic                           req_second_ref_hom,
   input  logic                           req_second_alt_hom,
   input  logic [ibs0gh_pkg::POS_W-1:0]   req_site_position,
   input  logic                           req_last_site,
   input  logic [ibs0gh_pkg::REG_W-1:0]   req_bin_select,
   // Result channel.
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic                           rsp_result_kind,
   output logic [ibs0gh_pkg::POS_W-1:0]   rsp_first_ibs0_position,
   output logic [ibs0gh_pkg::POS_W-1:0]   rsp_last_ibs0_position,
   output logic [ibs0gh_pkg::COUNT_W-1:0] rsp_bin_count
);

   localparam int AW = $clog2(MAX_BINS);
   localparam int PW = ibs0gh_pkg::POS_W;
   localparam int CW = ibs0gh_pkg::COUNT_W;
   localparam int RW = ibs0gh_pkg::REG_W;
   localparam int DW = ibs0gh_pkg::DIVISOR_W;

   ibs0gh_pkg::state_type state_ff, state_in;

   logic [AW-1:0] clr_addr_ff, clr_addr_in;
   logic [RW-1:0] bin_width_ff, bin_width_in;
   logic [RW-1:0] last_bin_ff, last_bin_in;
   logic [DW-1:0] divisor_ff, divisor_in;
   logic [PW-1:0] prev_ff, prev_in;
   logic [PW-1:0] start_ff, start_in;
   logic          seen_ff, seen_in;
   logic          res_pend_ff, res_pend_in;
   logic          res_kind_ff, res_kind_in;
   logic [PW-1:0] res_first_ff, res_first_in;
   logic [PW-1:0] res_last_ff, res_last_in;
   logic [CW-1:0] res_count_ff, res_count_in;
   logic          sel_oob_ff, sel_oob_in;
   logic [AW-1:0] bin_ff, bin_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          rsp_kind_ff, rsp_kind_in;
   logic [PW-1:0] rsp_first_ff, rsp_first_in;
   logic [PW-1:0] rsp_last_ff, rsp_last_in;
   logic [CW-1:0] rsp_count_ff, rsp_count_in;

   logic          ram_we;
   logic [AW-1:0] ram_waddr;
   logic [CW-1:0] ram_wdata;
   logic [AW-1:0] ram_raddr;
   logic [CW-1:0] ram_rdata;

   logic          accept;
   logic          ibs0;
   logic          div_start;
   logic          div_done;
   logic [PW-1:0] gap;
   logic [PW-1:0] quotient;
   logic [31:0]   top_bin;
   logic [31:0]   gap_bin;
   logic [31:0]   sel_wide;
   logic          seen_next;
   logic [PW-1:0] start_next;
   logic [PW-1:0] prev_next;
   logic [RW-1:0] width_eff;

   logic          in_clear;
   logic          clear_ok;
   logic          in_div;
   logic          fin_blocked;
   logic          fin_held;
   logic          pair_close;
   logic          pair_idle;

   // Transfer decode and the site classification.
   always_comb begin
      accept     = req_valid && !req_stall;
      ibs0       = (req_first_ref_hom ^ req_second_ref_hom) &&
                   (req_first_alt_hom ^ req_second_alt_hom);
      gap        = req_site_position - prev_ff;
      div_start  = accept && (req_action == ibs0gh_pkg::ACT_SITE) && ibs0 && seen_ff;
      seen_next  = seen_ff || ibs0;
      start_next = (ibs0 && !seen_ff) ? req_site_position : start_ff;
      prev_next  = ibs0 ? req_site_position : prev_ff;
      sel_wide   = 32'(req_bin_select);
   end

   // Bin index of a finished division, saturated at the effective last bin.
   always_comb begin
      top_bin = (32'(last_bin_ff) > 32'(MAX_BINS - 1)) ? 32'(MAX_BINS - 1)
                                                       : 32'(last_bin_ff);
      gap_bin = (32'(quotient) > top_bin) ? top_bin : 32'(quotient);
   end

   // Configuration registers and the bin span in base pairs.
   always_comb begin
      bin_width_in = bin_width_ff;
      last_bin_in  = last_bin_ff;
      if (csr_we) begin
         unique case (csr_index)
            ibs0gh_pkg::CSR_BIN_WIDTH_KB: bin_width_in = csr_wdata;
            ibs0gh_pkg::CSR_LAST_BIN:     last_bin_in  = csr_wdata;
         endcase
      end
      width_eff  = (bin_width_ff == '0) ? RW'(1) : bin_width_ff;
      divisor_in = DW'(DW'(width_eff) * DW'(ibs0gh_pkg::BP_PER_KB));
   end

   // Main controller: clearing sweep, item decode, histogram update, result.
   always_comb begin
      state_in     = state_ff;
      clr_addr_in  = clr_addr_ff;
      prev_in      = prev_ff;
      start_in     = start_ff;
      seen_in      = seen_ff;
      res_pend_in  = res_pend_ff;
      res_kind_in  = res_kind_ff;
      res_first_in = res_first_ff;
      res_last_in  = res_last_ff;
      res_count_in = res_count_ff;
      sel_oob_in   = sel_oob_ff;
      bin_in       = bin_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_kind_in  = rsp_kind_ff;
      rsp_first_in = rsp_first_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_count_in = rsp_count_ff;
      ram_we       = 1'b0;
      ram_waddr    = bin_ff;
      ram_wdata    = '0;
      ram_raddr    = bin_ff;

      unique case (state_ff)
         // Write zero to every bin once after reset.
         ibs0gh_pkg::ST_CLEAR: begin
            ram_we      = 1'b1;
            ram_waddr   = clr_addr_ff;
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_addr_ff == AW'(MAX_BINS - 1)) begin
               state_in = ibs0gh_pkg::ST_IDLE;
            end
         end

         // Take one item; pair state updates at once, gaps go to the divider.
         ibs0gh_pkg::ST_IDLE: begin
            if (accept) begin
               if (req_action == ibs0gh_pkg::ACT_READ) begin
                  ram_raddr   = sel_wide[AW-1:0];
                  sel_oob_in  = sel_wide >= 32'(MAX_BINS);
                  res_pend_in = 1'b1;
                  res_kind_in = ibs0gh_pkg::KIND_BIN;
                  res_first_in = '0;
                  res_last_in  = '0;
                  state_in    = ibs0gh_pkg::ST_RD_BIN;
               end else begin
                  seen_in  = seen_next;
                  start_in = start_next;
                  prev_in  = prev_next;
                  res_pend_in = req_last_site;
                  if (req_last_site) begin
                     res_kind_in  = ibs0gh_pkg::KIND_BOUNDS;
                     res_first_in = seen_next ? start_next : '0;
                     res_last_in  = seen_next ? prev_next : '0;
                     res_count_in = '0;
                     seen_in      = 1'b0;
                     start_in     = '0;
                     prev_in      = '0;
                  end
                  if (div_start) begin
                     state_in = ibs0gh_pkg::ST_DIV;
                  end else if (req_last_site) begin
                     state_in = ibs0gh_pkg::ST_FIN;
                  end
               end
            end
         end

         // Wait for the quotient, then read the selected bin.
         ibs0gh_pkg::ST_DIV: begin
            if (div_done) begin
               bin_in    = gap_bin[AW-1:0];
               ram_raddr = gap_bin[AW-1:0];
               state_in  = ibs0gh_pkg::ST_INC;
            end
         end

         // Bin read data is valid; capture it for the result.
         ibs0gh_pkg::ST_RD_BIN: begin
            res_count_in = sel_oob_ff ? '0 : ram_rdata;
            state_in     = ibs0gh_pkg::ST_FIN;
         end

         // Saturating increment written back to the same bin.
         ibs0gh_pkg::ST_INC: begin
            ram_we    = 1'b1;
            ram_waddr = bin_ff;
            ram_wdata = (ram_rdata == '1) ? ram_rdata : ram_rdata + 1'b1;
            state_in  = res_pend_ff ? ibs0gh_pkg::ST_FIN : ibs0gh_pkg::ST_IDLE;
         end

         // Move the pending result into the output register once it is free.
         ibs0gh_pkg::ST_FIN: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = res_kind_ff;
               rsp_first_in = res_first_ff;
               rsp_last_in  = res_last_ff;
               rsp_count_in = res_count_ff;
               res_pend_in  = 1'b0;
               state_in     = ibs0gh_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = ibs0gh_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ibs0gh_pkg::ST_CLEAR;
         clr_addr_ff  <= '0;
         bin_width_ff <= RW'(1);
         last_bin_ff  <= RW'(1000);
         divisor_ff   <= DW'(ibs0gh_pkg::BP_PER_KB);
         prev_ff      <= '0;
         start_ff     <= '0;
         seen_ff      <= 1'b0;
         res_pend_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         bin_width_ff <= bin_width_in;
         last_bin_ff  <= last_bin_in;
         divisor_ff   <= divisor_in;
         prev_ff      <= prev_in;
         start_ff     <= start_in;
         seen_ff      <= seen_in;
         res_pend_ff  <= res_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      res_kind_ff  <= res_kind_in;
      res_first_ff <= res_first_in;
      res_last_ff  <= res_last_in;
      res_count_ff <= res_count_in;
      sel_oob_ff   <= sel_oob_in;
      bin_ff       <= bin_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_first_ff <= rsp_first_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_count_ff <= rsp_count_in;
   end

   // Gap to bin number division.
   ibs0gh_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (gap),
      .divisor  (divisor_ff),
      .done     (div_done),
      .quotient (quotient)
   );

   // Histogram storage.
   ibs0gh_ram #(
      .WIDTH (CW),
      .DEPTH (MAX_BINS)
   ) u_hist_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign req_stall               = state_ff != ibs0gh_pkg::ST_IDLE;
   assign rsp_valid               = rsp_valid_ff;
   assign rsp_result_kind         = rsp_kind_ff;
   assign rsp_first_ibs0_position = rsp_first_ff;
   assign rsp_last_ibs0_position  = rsp_last_ff;
   assign rsp_bin_count           = rsp_count_ff;

   // Conditions used by the checks below.
   always_comb begin
      in_clear    = state_ff == ibs0gh_pkg::ST_CLEAR;
      clear_ok    = req_stall && ram_we && (ram_wdata == '0);
      in_div      = state_ff == ibs0gh_pkg::ST_DIV;
      fin_blocked = (state_ff == ibs0gh_pkg::ST_FIN) && rsp_valid_ff && rsp_stall;
      fin_held    = (state_ff == ibs0gh_pkg::ST_FIN) && res_pend_ff;
      pair_close  = accept && (req_action == ibs0gh_pkg::ACT_SITE) && req_last_site;
      pair_idle   = !seen_ff && (prev_ff == '0) && (start_ff == '0);
   end

   // Checks on the controller.
   `IBS0GH_ASSERT_SAME(a_clear_stalls, in_clear, clear_ok, "clear sweep must stall, write zero")
   `IBS0GH_ASSERT_SAME(a_div_in_div, div_done, in_div, "quotient done outside divide state")
   `IBS0GH_ASSERT_NEXT(a_fin_holds, fin_blocked, fin_held, "pending result dropped")
   `IBS0GH_ASSERT_NEXT(a_pair_closed, pair_close, pair_idle, "pair state not cleared")

endmodule

@@ hdl/ibs0gh_ram.sv @@
// ----------------------------------------------------------------------------
// IBS0 gap histogram RAM
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module ibs0gh_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

@@ hdl/ibs0gh_div.sv @@
// ----------------------------------------------------------------------------
// IBS0 gap histogram divider
// Restoring divider that produces one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ibs0gh_div (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [ibs0gh_pkg::POS_W-1:0]     dividend,
   input  logic [ibs0gh_pkg::DIVISOR_W-1:0] divisor,
   output logic                             done,
   output logic [ibs0gh_pkg::POS_W-1:0]     quotient
);

   localparam int CntW = $clog2(ibs0gh_pkg::POS_W);

   logic                             busy_ff, busy_in;
   logic                             done_ff, done_in;
   logic [CntW-1:0]                  cnt_ff, cnt_in;
   logic [ibs0gh_pkg::DIVISOR_W-1:0] rem_ff, rem_in;
   logic [ibs0gh_pkg::POS_W-1:0]     quo_ff, quo_in;

   logic [ibs0gh_pkg::DIVISOR_W:0]   trial;
   logic [ibs0gh_pkg::DIVISOR_W:0]   diff;
   logic                             fits;

   // One trial subtraction of the divisor from the shifted remainder.
   always_comb begin
      trial = {rem_ff, quo_ff[ibs0gh_pkg::POS_W-1]};
      diff  = trial - {1'b0, divisor};
      fits  = trial >= {1'b0, divisor};
   end

   // Iteration control; the caller must hold the divisor steady, and this block does not enforce it.
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = dividend;
      end else if (busy_ff) begin
         rem_in = fits ? diff[ibs0gh_pkg::DIVISOR_W-1:0] : trial[ibs0gh_pkg::DIVISOR_W-1:0];
         quo_in = {quo_ff[ibs0gh_pkg::POS_W-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CntW'(ibs0gh_pkg::POS_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule
